// ----- sv/timer_text_to_bcd_parser_defines.svh -----
// ----------------------------------------------------------------------------
// Timer text parser assertion macros
// Shared concurrent assertion forms used by the parser command queue.
// ----------------------------------------------------------------------------
`ifndef TIMER_TEXT_TO_BCD_PARSER_DEFINES_SVH
`define TIMER_TEXT_TO_BCD_PARSER_DEFINES_SVH

// The condition must never be true at a clock edge outside reset.
`define TTBP_ASSERT_NEVER(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

// The consequent must hold at the edge after the antecedent.
`define TTBP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/ttbp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer text parser package
// Constants, the command type passed from front to back, and small helpers.
// ----------------------------------------------------------------------------
package ttbp_pkg;

    localparam int MAX_BYTES   = 32;
    localparam int STAMP_WIDTH = 4;
    localparam int BYTE_W      = 8;
    localparam int INDEX_W     = 5;
    localparam int COUNT_W     = 6;
    localparam int POS_W       = $clog2(MAX_BYTES + 1);
    localparam int KIDX_W      = $clog2(STAMP_WIDTH);
    localparam int QDEPTH      = 2;
    localparam int QPTR_W      = $clog2(QDEPTH);
    localparam int ADDR_W      = 3;
    localparam int DATA_W      = 32;

    localparam logic [COUNT_W-1:0] TARGET_RESET = 6'd28;
    localparam logic [0:0]         REG_TARGET   = 1'b0;

    localparam logic [BYTE_W-1:0] OFF_EVEN  = 8'hff;
    localparam logic [BYTE_W-1:0] OFF_ODD   = 8'h0f;
    localparam logic [BYTE_W-1:0] CHAR_DASH = 8'h2d;
    localparam logic [BYTE_W-1:0] CHAR_PLUS = 8'h2b;
    localparam logic [BYTE_W-1:0] CHAR_ZERO = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_NINE = 8'h39;

    // One unit of work for the back end: up to four bytes, or the end status.
    typedef struct packed {
        logic [KIDX_W-1:0]                  last_k;
        logic [INDEX_W-1:0]                 base_index;
        logic                               is_status;
        logic                               success;
        logic [STAMP_WIDTH-1:0][BYTE_W-1:0] bytes;
    } ttbp_cmd_t;

    function automatic logic is_digit(input logic [BYTE_W-1:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

    function automatic logic [BYTE_W-1:0] off_code(input logic odd);
        return odd ? OFF_ODD : OFF_EVEN;
    endfunction

endpackage

// ----- sv/ttbp_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer text parser front end
// Accepts characters, tracks the group and position, and queues commands.
// ----------------------------------------------------------------------------
module ttbp_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [ttbp_pkg::BYTE_W-1:0]   s_ch,
    input  logic                          s_end_of_string,
    input  logic [ttbp_pkg::COUNT_W-1:0]  target_byte_count,
    input  logic                          q_full,
    output logic                          q_push,
    output ttbp_pkg::ttbp_cmd_t           q_data
);
    import ttbp_pkg::*;

    typedef enum logic [1:0] {
        PH_START,
        PH_HOUR2,
        PH_MIN1,
        PH_MIN2
    } phase_t;

    phase_t                  phase_reg, phase_next;
    logic [POS_W-1:0]        pos_reg, pos_next;
    logic                    stopped_reg, stopped_next;
    logic                    failed_reg, failed_next;
    logic [3:0]              first_reg, first_next;
    logic [BYTE_W-1:0]       hours_reg, hours_next;
    logic [1:0][1:0][BYTE_W-1:0] hist_reg;

    logic                    accept;
    logic [POS_W-1:0]        lim;
    logic [POS_W:0]          pos_p1;
    logic [POS_W:0]          pos_p4;
    logic                    digit;
    logic [BYTE_W-1:0]       second_bcd;
    logic                    half;
    logic                    hist_wr;
    logic [1:0][BYTE_W-1:0]  hist_wr_data;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign digit   = is_digit(s_ch);
    assign pos_p1  = {1'b0, pos_reg} + (POS_W+1)'(1);
    assign pos_p4  = {1'b0, pos_reg} + (POS_W+1)'(STAMP_WIDTH);
    // Positions only ever advance by two or four, so a pair never straddles a half.
    assign half    = pos_reg[1];

    always_comb begin
        if (int'(target_byte_count) > MAX_BYTES) begin
            lim = POS_W'(MAX_BYTES);
        end else begin
            lim = POS_W'(target_byte_count);
        end
    end

    // Second character of a pair: a digit completes it unless the pair already stopped.
    always_comb begin
        if (!stopped_reg && digit) begin
            second_bcd = {first_reg, s_ch[3:0]};
        end else begin
            second_bcd = {4'h0, first_reg};
        end
    end

    always_comb begin
        phase_next   = phase_reg;
        pos_next     = pos_reg;
        stopped_next = stopped_reg;
        failed_next  = failed_reg;
        first_next   = first_reg;
        hours_next   = hours_reg;
        q_push       = 1'b0;
        q_data       = '0;
        hist_wr      = 1'b0;
        hist_wr_data = '0;

        if (accept) begin
            if (s_end_of_string) begin
                q_push            = 1'b1;
                q_data.is_status  = 1'b1;
                q_data.success    = !failed_reg && (phase_reg == PH_START) && (pos_reg == lim);
                phase_next        = PH_START;
                pos_next          = '0;
                stopped_next      = 1'b0;
                failed_next       = 1'b0;
                first_next        = '0;
                hours_next        = '0;
            end else if (!failed_reg) begin
                unique case (phase_reg)
                    PH_START: begin
                        if (pos_reg < lim) begin
                            if (s_ch == CHAR_DASH) begin
                                if (pos_p1 >= {1'b0, lim}) begin
                                    failed_next = 1'b1;
                                end else begin
                                    q_push            = 1'b1;
                                    q_data.last_k     = KIDX_W'(1);
                                    q_data.base_index = INDEX_W'(pos_reg);
                                    q_data.bytes[0]   = off_code(pos_reg[0]);
                                    q_data.bytes[1]   = off_code(pos_p1[0]);
                                    hist_wr           = 1'b1;
                                    hist_wr_data[0]   = off_code(pos_reg[0]);
                                    hist_wr_data[1]   = off_code(pos_p1[0]);
                                    pos_next          = POS_W'(pos_reg + POS_W'(2));
                                end
                            end else if (s_ch == CHAR_PLUS) begin
                                if ((pos_reg < POS_W'(STAMP_WIDTH)) || (pos_p4 > {1'b0, lim})) begin
                                    failed_next = 1'b1;
                                end else begin
                                    // Replaying the last four bytes leaves the history as it is.
                                    q_push            = 1'b1;
                                    q_data.last_k     = KIDX_W'(STAMP_WIDTH - 1);
                                    q_data.base_index = INDEX_W'(pos_reg);
                                    q_data.bytes[0]   = hist_reg[half][0];
                                    q_data.bytes[1]   = hist_reg[half][1];
                                    q_data.bytes[2]   = hist_reg[!half][0];
                                    q_data.bytes[3]   = hist_reg[!half][1];
                                    pos_next          = POS_W'(pos_p4);
                                end
                            end else begin
                                if (pos_p1 >= {1'b0, lim}) begin
                                    failed_next = 1'b1;
                                end else begin
                                    first_next   = digit ? s_ch[3:0] : 4'h0;
                                    stopped_next = !digit;
                                    phase_next   = PH_HOUR2;
                                end
                            end
                        end
                    end
                    PH_HOUR2: begin
                        hours_next   = second_bcd;
                        stopped_next = 1'b1;
                        phase_next   = PH_MIN1;
                    end
                    PH_MIN1: begin
                        first_next   = digit ? s_ch[3:0] : 4'h0;
                        stopped_next = !digit;
                        phase_next   = PH_MIN2;
                    end
                    PH_MIN2: begin
                        q_push            = 1'b1;
                        q_data.last_k     = KIDX_W'(1);
                        q_data.base_index = INDEX_W'(pos_reg);
                        q_data.bytes[0]   = second_bcd;
                        q_data.bytes[1]   = hours_reg;
                        hist_wr           = 1'b1;
                        hist_wr_data[0]   = second_bcd;
                        hist_wr_data[1]   = hours_reg;
                        stopped_next      = 1'b1;
                        pos_next          = POS_W'(pos_reg + POS_W'(2));
                        phase_next        = PH_START;
                    end
                    default: begin
                        phase_next = PH_START;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_START;
            pos_reg     <= '0;
            stopped_reg <= 1'b0;
            failed_reg  <= 1'b0;
            first_reg   <= '0;
            hours_reg   <= '0;
        end else begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            stopped_reg <= stopped_next;
            failed_reg  <= failed_next;
            first_reg   <= first_next;
            hours_reg   <= hours_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (hist_wr) begin
            hist_reg[half] <= hist_wr_data;
        end
    end

endmodule

// ----- sv/ttbp_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer text parser command queue
// Short first-in first-out buffer between the front and back ends.
// ----------------------------------------------------------------------------
`include "timer_text_to_bcd_parser_defines.svh"

module ttbp_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  ttbp_pkg::ttbp_cmd_t  push_data,
    input  logic                 pop,
    output ttbp_pkg::ttbp_cmd_t  head,
    output logic                 head_valid,
    output logic                 full
);
    import ttbp_pkg::*;

    ttbp_cmd_t           entry_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]     count_reg, count_next;

    assign head       = entry_reg[rd_ptr_reg];
    assign head_valid = (count_reg != '0);
    assign full       = (count_reg == (QPTR_W+1)'(QDEPTH));

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = QPTR_W'(wr_ptr_reg + QPTR_W'(1));
        end
        if (pop) begin
            rd_ptr_next = QPTR_W'(rd_ptr_reg + QPTR_W'(1));
        end
        if (push && !pop) begin
            count_next = count_reg + (QPTR_W+1)'(1);
        end else if (pop && !push) begin
            count_next = count_reg - (QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    `TTBP_ASSERT_NEVER(a_no_push_full, aclk, aresetn, push && full, "push into a full queue")
    `TTBP_ASSERT_NEVER(a_no_pop_empty, aclk, aresetn, pop && !head_valid, "pop from an empty queue")
    `TTBP_ASSERT_NEVER(a_count_bound, aclk, aresetn, count_reg > (QPTR_W+1)'(QDEPTH), "queue count past depth")
    `TTBP_ASSERT_NEXT(a_push_grows, aclk, aresetn, push && !pop, count_reg == $past(count_reg) + 1'b1, "push did not grow the queue")

endmodule

// ----- sv/ttbp_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer text parser back end
// Expands each queued command into result transfers through an output register.
// ----------------------------------------------------------------------------
module ttbp_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  ttbp_pkg::ttbp_cmd_t           q_head,
    input  logic                          q_head_valid,
    output logic                          q_pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [ttbp_pkg::BYTE_W-1:0]   m_byte_value,
    output logic [ttbp_pkg::INDEX_W-1:0]  m_byte_index,
    output logic                          m_is_status,
    output logic                          m_success,
    output logic                          m_last
);
    import ttbp_pkg::*;

    logic [KIDX_W-1:0]   k_reg, k_next;
    logic                m_valid_reg;
    logic [BYTE_W-1:0]   value_reg;
    logic [INDEX_W-1:0]  index_reg;
    logic                status_reg;
    logic                success_reg;
    logic                last_reg;
    logic                out_free;
    logic                take;
    logic                elem_last;

    assign out_free  = !m_valid_reg || m_ready;
    assign take      = out_free && q_head_valid;
    assign elem_last = (k_reg == q_head.last_k);
    assign q_pop     = take && elem_last;

    always_comb begin
        k_next = k_reg;
        if (take) begin
            k_next = elem_last ? '0 : KIDX_W'(k_reg + KIDX_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            k_reg <= k_next;
            if (out_free) begin
                m_valid_reg <= q_head_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            value_reg   <= q_head.bytes[k_reg];
            index_reg   <= INDEX_W'(q_head.base_index + INDEX_W'(k_reg));
            status_reg  <= q_head.is_status;
            success_reg <= q_head.success;
            last_reg    <= elem_last;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_byte_value = value_reg;
    assign m_byte_index = index_reg;
    assign m_is_status  = status_reg;
    assign m_success    = success_reg;
    assign m_last       = last_reg;

endmodule

// ----- sv/timer_text_to_bcd_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer text to BCD parser
// Parses a timer string character by character into indexed BCD bytes.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (s_valid/s_ready) carries one character per transfer;
// s_end_of_string closes the string and causes a single status result.
// The result channel (m_valid/m_ready) carries data bytes with their index,
// or the status, with m_last on the final result caused by a character.
// A completed HHMM group gives two results, '-' gives two, '+' gives four and
// the end of string gives one; all other characters give none.
// A character's command is written into the queue at its transfer edge and is
// then loaded into the output register, which presents the results in turn;
// the load waits while the receiver stalls a result held in that register.
// The back end hands out one result per cycle while the receiver is ready, so
// throughput is one character per cycle for characters with at most one result
// and is bounded by the result count otherwise. A two-entry command queue
// decouples the parsing front end from the output register, so the front end
// keeps taking characters while the receiver stalls until the queue fills.
// Reset (aresetn low at a clock edge) empties the queue and output, clears
// the parse state, and sets target_byte_count to 28. The register sits at
// byte address 0 of the APB port; it is to be written only while the block
// is idle, which the user must ensure, as the block itself does not enforce it.
// ----------------------------------------------------------------------------
module timer_text_to_bcd_parser (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Character input
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [ttbp_pkg::BYTE_W-1:0]   s_ch,
    input  logic                          s_end_of_string,
    // Results
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [ttbp_pkg::BYTE_W-1:0]   m_byte_value,
    output logic [ttbp_pkg::INDEX_W-1:0]  m_byte_index,
    output logic                          m_is_status,
    output logic                          m_success,
    output logic                          m_last,
    // Configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ttbp_pkg::ADDR_W-1:0]   paddr,
    input  logic [ttbp_pkg::DATA_W-1:0]   pwdata,
    output logic [ttbp_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import ttbp_pkg::*;

    logic [COUNT_W-1:0]  target_reg;
    logic                cfg_write;
    logic                target_sel;
    ttbp_cmd_t           push_data;
    ttbp_cmd_t           head;
    logic                push;
    logic                pop;
    logic                head_valid;
    logic                full;

    // The port never inserts wait states. Word address bit selects the register.
    assign pready     = 1'b1;
    assign target_sel = (paddr[ADDR_W-1] == REG_TARGET);
    assign cfg_write  = psel && penable && pwrite && target_sel;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg <= TARGET_RESET;
        end else if (cfg_write) begin
            target_reg <= pwdata[COUNT_W-1:0];
        end
    end

    // Reads of the unused word return zero.
    always_comb begin
        prdata = '0;
        if (target_sel) begin
            prdata = DATA_W'(target_reg);
        end
    end

    // Front end: parses characters and issues one command per emitting character.
    ttbp_front u_front (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_ch              (s_ch),
        .s_end_of_string   (s_end_of_string),
        .target_byte_count (target_reg),
        .q_full            (full),
        .q_push            (push),
        .q_data            (push_data)
    );

    // Queue between front and back ends so each side can stall on its own.
    ttbp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_data  (push_data),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid),
        .full       (full)
    );

    // Back end: one result transfer per cycle from the head command while the receiver is ready.
    ttbp_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_head       (head),
        .q_head_valid (head_valid),
        .q_pop        (pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_byte_value (m_byte_value),
        .m_byte_index (m_byte_index),
        .m_is_status  (m_is_status),
        .m_success    (m_success),
        .m_last       (m_last)
    );

endmodule
